FILE: rtl/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// shared constants, codes and control types of the circular deque
// ---------------------------------------------------------------------------
package cdq_pkg;

	localparam int unsigned CDQ_DEPTH  = 32;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned QLEN_W     = 6;
	localparam int unsigned QLEN_RESET = 32;

	// command codes
	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd1;
	localparam logic [1:0] CMD_PUSH_REAR  = 2'd2;
	localparam logic [1:0] CMD_POP_REAR   = 2'd3;

	// status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic exec;
		logic finish;
	} cdq_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic pop_go;
	} cdq_sts_t;

endpackage

FILE: rtl/cdq_ctrl.sv
// ---------------------------------------------------------------------------
// cdq_ctrl
// sequencer of the circular deque: accept, execute, optional pop read
// ---------------------------------------------------------------------------
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     cfg_valid,
	input  cdq_sts_t sts,
	output cdq_ctl_t ctl,
	output logic     busy,
	output logic     done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (sts.pop_go) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign ctl.cfg_wr = cfg_valid && (state_q == S_IDLE);
	assign ctl.load   = start && (state_q == S_IDLE);
	assign ctl.exec   = (state_q == S_EXEC);
	assign ctl.finish = (state_q == S_POP);

endmodule

FILE: rtl/cdq_dpath.sv
// ---------------------------------------------------------------------------
// cdq_dpath
// slot memory, front/rear indices, empty flag, length and result registers
// ---------------------------------------------------------------------------
module cdq_dpath
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = CDQ_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cdq_ctl_t                 ctl,
	input  logic [QLEN_W-1:0]        cfg_data,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] data_in,
	output cdq_sts_t                 sts,
	output logic signed [DATA_W-1:0] data_out,
	output logic [1:0]               status
);

	localparam int unsigned IDX_W   = $clog2(DEPTH);
	localparam int unsigned LEN_W   = $clog2(DEPTH + 1);
	localparam int unsigned CW      = (LEN_W > QLEN_W) ? LEN_W : QLEN_W;
	localparam int unsigned LEN_RST = (QLEN_RESET > DEPTH) ? DEPTH : QLEN_RESET;

	logic [1:0]               cmd_q;
	logic signed [DATA_W-1:0] data_q;
	logic [IDX_W-1:0]         front_q, rear_q;
	logic                     empty_q;
	logic [LEN_W-1:0]         len_q;
	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rd_q;
	logic signed [DATA_W-1:0] data_out_q;
	logic [1:0]               status_q;

	logic [CW-1:0]    cfg_ext;
	logic [LEN_W-1:0] len_nxt;
	logic [IDX_W-1:0] last_idx, front_dec, front_inc, rear_dec, rear_inc;
	logic             is_push;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx, rd_idx;
	logic [IDX_W-1:0] front_nxt, rear_nxt;
	logic             empty_nxt;
	logic [1:0]       st;
	logic             pop_go;

	// length clamp to 1..DEPTH
	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext == '0)
			len_nxt = LEN_W'(1);
		else if (cfg_ext > CW'(DEPTH))
			len_nxt = LEN_W'(DEPTH);
		else
			len_nxt = LEN_W'(cfg_ext);
	end

	// wrapped neighbor indices
	always_comb begin
		last_idx  = IDX_W'(len_q - LEN_W'(1));
		front_dec = (front_q == '0) ? last_idx : front_q - IDX_W'(1);
		rear_dec  = (rear_q == '0) ? last_idx : rear_q - IDX_W'(1);
		front_inc = ((LEN_W'(front_q) + LEN_W'(1)) >= len_q) ? '0 : front_q + IDX_W'(1);
		rear_inc  = ((LEN_W'(rear_q) + LEN_W'(1)) >= len_q) ? '0 : rear_q + IDX_W'(1);
	end

	// command decision
	always_comb begin
		is_push   = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_REAR);
		wr_en     = 1'b0;
		wr_idx    = '0;
		rd_idx    = front_q;
		front_nxt = front_q;
		rear_nxt  = rear_q;
		empty_nxt = empty_q;
		st        = STS_DONE;
		pop_go    = 1'b0;
		if (is_push) begin
			if (empty_q) begin
				wr_en     = 1'b1;
				front_nxt = '0;
				rear_nxt  = '0;
				empty_nxt = 1'b0;
			end else if (cmd_q == CMD_PUSH_FRONT) begin
				if (front_dec == rear_q) begin
					st = STS_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_idx    = front_dec;
					front_nxt = front_dec;
				end
			end else begin
				if (rear_inc == front_q) begin
					st = STS_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_idx   = rear_inc;
					rear_nxt = rear_inc;
				end
			end
		end else begin
			if (empty_q) begin
				st = STS_EMPTY;
			end else begin
				pop_go = 1'b1;
				rd_idx = (cmd_q == CMD_POP_FRONT) ? front_q : rear_q;
				if (front_q == rear_q) begin
					front_nxt = '0;
					rear_nxt  = '0;
					empty_nxt = 1'b1;
				end else if (cmd_q == CMD_POP_FRONT) begin
					front_nxt = front_inc;
				end else begin
					rear_nxt = rear_dec;
				end
			end
		end
	end

	assign sts.pop_go = ctl.exec && pop_go;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
			len_q   <= LEN_W'(LEN_RST);
		end else if (ctl.cfg_wr) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
			len_q   <= len_nxt;
		end else if (ctl.exec) begin
			front_q <= front_nxt;
			rear_q  <= rear_nxt;
			empty_q <= empty_nxt;
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			data_q <= data_in;
		end
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) mem_q[wr_idx] <= data_q;
		if (ctl.exec) rd_q <= mem_q[rd_idx];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.exec && !pop_go) begin
			data_out_q <= '0;
			status_q   <= st;
		end else if (ctl.finish) begin
			data_out_q <= rd_q;
			status_q   <= STS_DONE;
		end
	end

	assign data_out = data_out_q;
	assign status   = status_q;

endmodule

FILE: rtl/circular_deque_top.sv
// ---------------------------------------------------------------------------
// circular_deque_top
// double-ended queue in a circular slot memory with programmable length
// ---------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low; its result shows
// on data_out and status for exactly one cycle while done is high, and the
// receiver has no way to stall it. a push or a refused command is resolved
// in the execute state alone, a successful pop goes on through the pop read
// state, because the slot memory read is registered and the popped word
// leaves through the result register in the cycle after that read. a new
// transaction may be started in the very cycle done is high. writing the
// length register (cfg_valid with cfg_ready) empties the queue; the length is
// clamped to 1..DEPTH, and cfg_ready is high only while the block is idle.
// ---------------------------------------------------------------------------
module circular_deque_top
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = CDQ_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] data_in,
	// result strobe
	output logic                     done,
	output logic signed [DATA_W-1:0] data_out,
	output logic [1:0]               status,
	// length register write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [QLEN_W-1:0]        cfg_data
);

	cdq_ctl_t ctl;
	cdq_sts_t sts;

	// sequencer: idle -> execute -> (pop read) -> idle
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.ctl       (ctl),
		.busy      (busy),
		.done      (done)
	);

	// indices, slot memory and result registers
	cdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.data_in  (data_in),
		.sts      (sts),
		.data_out (data_out),
		.status   (status)
	);

	// length writes only land between transactions
	assign cfg_ready = !busy;

endmodule

FILE: rtl/cdq_checker.sv
// ---------------------------------------------------------------------------
// cdq_checker
// port-level checks of the circular deque, bound to the top level
// ---------------------------------------------------------------------------
module cdq_checker
	import cdq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [DATA_W-1:0] data_out,
	input logic [1:0]               status,
	input logic                     cfg_ready
);

	// an accepted transaction makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	// a result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// a refused command returns zero data
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STS_DONE) |-> (data_out == '0))
		else $error("refused transaction returned nonzero data");

	// the result is shown while the block is already free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && cfg_ready))
		else $error("result shown while busy");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.data_out  (data_out),
	.status    (status),
	.cfg_ready (cfg_ready)
);
